@@ src/pinp_pkg.sv @@
// Shared types and constants of the palette index nibble packer.
package pinp_pkg;

  localparam int unsigned ROW_WIDTH_W = 7;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned IDX_W       = 4;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd16;

  localparam logic CFG_ROW_WIDTH = 1'b0;
  localparam logic CFG_MIRROR    = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_PALETTE  = 2'd1,
    KIND_OVERFLOW = 2'd2
  } result_kind_t;

  typedef struct packed {
    result_kind_t       kind;
    logic [COLOR_W-1:0] data;
    logic [IDX_W-1:0]   slot;
    logic               last;
  } result_t;

endpackage

@@ src/pinp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pinp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pinp_out_reg.sv @@
// Output register of the result channel with valid and stall.
module pinp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  pinp_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output pinp_pkg::result_t res_q
);

  logic              valid_r;
  pinp_pkg::result_t res_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule

@@ src/palette_index_nibble_packer_core.sv @@
// Top level of the 4bpp palette index nibble packer.
// A pixel is searched against the stored palette colors, one palette RAM read per cycle,
// then placed and emitted; each mirrored row byte takes up to two row RAM reads and each
// dumped palette entry one palette RAM read. Pixels are taken one at a time.
// Synchronous active-low reset clears the counters, the pair and row state, the registers
// and the output register; neither RAM is cleared.
module palette_index_nibble_packer_core #(
  parameter int PALETTE_SIZE = 16,
  parameter int ROW_MAX      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_high,
  input  logic [7:0]  in_pixel_low,
  input  logic        in_end_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_data_value,
  output logic [3:0]  out_palette_slot,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int CW  = $clog2(PALETTE_SIZE + 2);
  localparam int AW  = $clog2(PALETTE_SIZE);
  localparam int CCW = $clog2(ROW_MAX + 1);
  localparam int RAW = $clog2(ROW_MAX);
  localparam int IW  = pinp_pkg::IDX_W;
  localparam int KW  = pinp_pkg::COLOR_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SRCH    = 7'b0000010,
    S_PLACE   = 7'b0000100,
    S_EMIT    = 7'b0001000,
    S_ROW_HI  = 7'b0010000,
    S_ROW_OUT = 7'b0100000,
    S_PAL_OUT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [pinp_pkg::ROW_WIDTH_W-1:0] row_width_r;
  logic                             mirror_r;

  logic [CW-1:0]  count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  logic [IW-1:0]  held_r, held_nxt;
  logic           phase_r, phase_nxt;
  logic [CCW-1:0] col_r, col_nxt;

  logic [KW-1:0]  color_r, color_nxt;
  logic           eoi_r, eoi_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic           found_r, found_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;

  logic           pair_v_r, pair_v_nxt;
  logic           pair_first_r, pair_first_nxt;
  logic [7:0]     pair_data_r, pair_data_nxt;
  logic [CCW-1:0] row_k_r, row_k_nxt;
  logic           err_r, err_nxt;
  logic [CW-1:0]  dump_n_r, dump_n_nxt;
  logic [CW-1:0]  dump_j_r, dump_j_nxt;
  logic [IW-1:0]  hi_r, hi_nxt;

  logic           pal_we, pal_re;
  logic [AW-1:0]  pal_raddr;
  logic [KW-1:0]  pal_rdata;
  logic           row_we, row_re;
  logic [RAW-1:0] row_raddr;
  logic [IW-1:0]  row_rdata;

  logic              out_load, out_free;
  pinp_pkg::result_t out_res, out_q;

  logic [CW-1:0]  used;
  logic [CCW-1:0] w_eff;
  logic           new_ok;
  logic [IW-1:0]  idx_new;
  logic [CW-1:0]  cnt_after;
  logic           ovf_after;
  logic [CCW-1:0] col_new;
  logic           flush_now;
  logic [IW-1:0]  held_after;
  logic           phase_after;
  logic [CCW-1:0] k_next;
  logic           no_dump;

  assign used = (count_r >= CW'(PALETTE_SIZE)) ? CW'(PALETTE_SIZE) : count_r;

  always_comb begin
    if (32'(row_width_r) > ROW_MAX) begin
      w_eff = CCW'(ROW_MAX);
    end else if (row_width_r < 7'd2) begin
      w_eff = CCW'(2);
    end else begin
      w_eff = CCW'(row_width_r);
    end
    w_eff[0] = 1'b0;
  end

  always_comb begin
    new_ok      = count_r < CW'(PALETTE_SIZE);
    idx_new     = found_r ? idx_r : (new_ok ? IW'(count_r) : '0);
    cnt_after   = found_r ? count_r : (new_ok ? count_r + CW'(1) : CW'(PALETTE_SIZE + 1));
    ovf_after   = ovf_r || (!found_r && !new_ok);
    col_new     = col_r + CCW'(1);
    flush_now   = mirror_r && (col_new >= w_eff);
    held_after  = held_r;
    phase_after = phase_r;
    if (!mirror_r) begin
      if (phase_r) begin
        phase_after = 1'b0;
      end else begin
        held_after  = idx_new;
        phase_after = 1'b1;
      end
    end
  end

  assign k_next  = (row_k_r >= CCW'(2)) ? row_k_r - CCW'(2) : '0;
  assign no_dump = !err_r && (dump_n_r == '0);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    held_nxt       = held_r;
    phase_nxt      = phase_r;
    col_nxt        = col_r;
    color_nxt      = color_r;
    eoi_nxt        = eoi_r;
    j_nxt          = j_r;
    found_nxt      = found_r;
    idx_nxt        = idx_r;
    pair_v_nxt     = pair_v_r;
    pair_first_nxt = pair_first_r;
    pair_data_nxt  = pair_data_r;
    row_k_nxt      = row_k_r;
    err_nxt        = err_r;
    dump_n_nxt     = dump_n_r;
    dump_j_nxt     = dump_j_r;
    hi_nxt         = hi_r;
    pal_we         = 1'b0;
    pal_re         = 1'b0;
    pal_raddr      = j_r;
    row_we         = 1'b0;
    row_re         = 1'b0;
    row_raddr      = RAW'(row_k_r - CCW'(1));
    out_load       = 1'b0;
    out_res        = '{kind: pinp_pkg::KIND_BYTE, data: '0, slot: '0, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          color_nxt = {in_pixel_high, in_pixel_low};
          eoi_nxt   = in_end_of_image;
          j_nxt     = '0;
          found_nxt = 1'b0;
          pal_re    = 1'b1;
          pal_raddr = '0;
          state_nxt = (used == '0) ? S_PLACE : S_SRCH;
        end
      end
      S_SRCH: begin
        if (pal_rdata == color_r) begin
          found_nxt = 1'b1;
          idx_nxt   = IW'(j_r);
          state_nxt = S_PLACE;
        end else if ((CW'(j_r) + CW'(1)) < used) begin
          j_nxt     = j_r + AW'(1);
          pal_re    = 1'b1;
          pal_raddr = j_r + AW'(1);
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        pal_we     = !found_r && new_ok;
        row_we     = mirror_r;
        count_nxt  = cnt_after;
        ovf_nxt    = ovf_after;
        held_nxt   = held_after;
        phase_nxt  = phase_after;
        pair_first_nxt = !flush_now;
        pair_v_nxt = (!mirror_r && phase_r) || (eoi_r && phase_after);
        pair_data_nxt = (!mirror_r && phase_r) ? {held_r, idx_new} : {held_after, 4'h0};
        if (mirror_r) begin
          row_k_nxt = (flush_now || eoi_r) ? col_new : '0;
          col_nxt   = (flush_now || eoi_r) ? '0 : col_new;
        end else begin
          row_k_nxt = eoi_r ? col_r : '0;
          col_nxt   = eoi_r ? '0 : col_r;
        end
        err_nxt    = eoi_r && ovf_after;
        dump_n_nxt = (eoi_r && !ovf_after) ? cnt_after : '0;
        dump_j_nxt = '0;
        if (eoi_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          held_nxt  = '0;
          phase_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (pair_v_r && pair_first_r) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_res    = '{kind: pinp_pkg::KIND_BYTE, data: KW'(pair_data_r), slot: '0,
                           last: (row_k_r == '0) && no_dump};
            pair_v_nxt = 1'b0;
          end
        end else if (row_k_r != '0) begin
          row_re    = 1'b1;
          state_nxt = S_ROW_HI;
        end else if (pair_v_r) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_res    = '{kind: pinp_pkg::KIND_BYTE, data: KW'(pair_data_r), slot: '0,
                           last: no_dump};
            pair_v_nxt = 1'b0;
          end
        end else if (err_r) begin
          if (out_free) begin
            out_load = 1'b1;
            out_res  = '{kind: pinp_pkg::KIND_OVERFLOW, data: KW'(PALETTE_SIZE + 1),
                         slot: '0, last: 1'b1};
            err_nxt  = 1'b0;
          end
        end else if (dump_j_r < dump_n_r) begin
          pal_re    = 1'b1;
          pal_raddr = dump_j_r[AW-1:0];
          state_nxt = S_PAL_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROW_HI: begin
        hi_nxt    = row_rdata;
        row_re    = row_k_r >= CCW'(2);
        row_raddr = RAW'(row_k_r - CCW'(2));
        state_nxt = S_ROW_OUT;
      end
      S_ROW_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_res   = '{kind: pinp_pkg::KIND_BYTE,
                        data: KW'({hi_r, (row_k_r >= CCW'(2)) ? row_rdata : 4'h0}),
                        slot: '0,
                        last: (k_next == '0) && !pair_v_r && no_dump};
          row_k_nxt = k_next;
          state_nxt = S_EMIT;
        end
      end
      S_PAL_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_res    = '{kind: pinp_pkg::KIND_PALETTE, data: pal_rdata,
                         slot: IW'(dump_j_r), last: (dump_j_r + CW'(1)) == dump_n_r};
          dump_j_nxt = dump_j_r + CW'(1);
          state_nxt  = S_EMIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_width_r  <= pinp_pkg::ROW_WIDTH_RESET;
      mirror_r     <= 1'b0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      held_r       <= '0;
      phase_r      <= 1'b0;
      col_r        <= '0;
      pair_v_r     <= 1'b0;
      pair_first_r <= 1'b0;
      row_k_r      <= '0;
      err_r        <= 1'b0;
      dump_n_r     <= '0;
      dump_j_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
      col_r        <= col_nxt;
      pair_v_r     <= pair_v_nxt;
      pair_first_r <= pair_first_nxt;
      row_k_r      <= row_k_nxt;
      err_r        <= err_nxt;
      dump_n_r     <= dump_n_nxt;
      dump_j_r     <= dump_j_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pinp_pkg::CFG_ROW_WIDTH: row_width_r <= cfg_wdata;
          pinp_pkg::CFG_MIRROR:    mirror_r    <= cfg_wdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r     <= color_nxt;
    eoi_r       <= eoi_nxt;
    j_r         <= j_nxt;
    found_r     <= found_nxt;
    idx_r       <= idx_nxt;
    pair_data_r <= pair_data_nxt;
    hi_r        <= hi_nxt;
  end

  pinp_ram #(
    .WIDTH (KW),
    .DEPTH (PALETTE_SIZE)
  ) u_palette_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (count_r[AW-1:0]),
    .wdata (color_r),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  pinp_ram #(
    .WIDTH (IW),
    .DEPTH (ROW_MAX)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (col_r[RAW-1:0]),
    .wdata (idx_new),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  pinp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .res       (out_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (out_q)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign out_result_kind  = out_q.kind;
  assign out_data_value   = out_q.data;
  assign out_palette_slot = out_q.slot;
  assign out_last_result  = out_q.last;

  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CW'(PALETTE_SIZE + 1)))
    else $error("overflow set without saturated palette count");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < CCW'(ROW_MAX))
    else $error("row column count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded into occupied output register");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pair_v_r && (row_k_r == '0) && !err_r && (dump_j_r >= dump_n_r)))
    else $error("idle with results still pending");

endmodule

@@ bench/pinp_monitor.sv @@
// Checker that predicts the packer's results from observed transfers and compares them.
`timescale 1ns / 1ps
module pinp_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       in_pixel_high,
  input  logic [7:0]                       in_pixel_low,
  input  logic                             in_end_of_image,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [1:0]                       out_result_kind,
  input  logic [15:0]                      out_data_value,
  input  logic [3:0]                       out_palette_slot,
  input  logic                             out_last_result,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [pinp_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
  output int unsigned                      mismatches,
  output int unsigned                      awaiting
);

  localparam int PAL_SLOTS = 16;
  localparam int ROW_SLOTS = 64;

  logic [pinp_pkg::ROW_WIDTH_W-1:0] width_reg;
  logic                             mirror_reg;
  logic [pinp_pkg::COLOR_W-1:0]     colors [PAL_SLOTS];
  int unsigned                      color_count;
  logic                             overflowed;
  logic [pinp_pkg::IDX_W-1:0]       held_nibble;
  logic                             nibble_held;
  int unsigned                      columns;
  logic [pinp_pkg::IDX_W-1:0]       row_nibbles [ROW_SLOTS];
  pinp_pkg::result_t                due_results [$];
  int unsigned                      errors = 0;

  task automatic queue_result(pinp_pkg::result_kind_t kind,
                              logic [pinp_pkg::COLOR_W-1:0] data,
                              logic [pinp_pkg::IDX_W-1:0] slot);
    pinp_pkg::result_t r;
    r.kind = kind;
    r.data = data;
    r.slot = slot;
    r.last = 1'b0;
    due_results.push_back(r);
  endtask

  // The held row comes out last pixel first, two nibbles per byte.
  task automatic emit_row();
    int unsigned k;
    logic [pinp_pkg::IDX_W-1:0] hi;
    logic [pinp_pkg::IDX_W-1:0] lo;
    k = columns;
    while (k > 0) begin
      hi = row_nibbles[(k - 1) % ROW_SLOTS];
      lo = '0;
      k--;
      if (k > 0) begin
        lo = row_nibbles[(k - 1) % ROW_SLOTS];
        k--;
      end
      queue_result(pinp_pkg::KIND_BYTE, {8'h00, hi, lo}, '0);
    end
    columns = 0;
  endtask

  task automatic encode_pixel(logic [pinp_pkg::COLOR_W-1:0] color, logic eoi);
    int unsigned used;
    int unsigned w;
    int unsigned start;
    logic [pinp_pkg::IDX_W-1:0] idx;
    bit hit;
    start = due_results.size();
    used = (color_count < PAL_SLOTS) ? color_count : PAL_SLOTS;
    idx = '0;
    hit = 1'b0;
    for (int j = 0; j < used && !hit; j++) begin
      if (colors[j] == color) begin
        idx = j[pinp_pkg::IDX_W-1:0];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (color_count < PAL_SLOTS) begin
        colors[color_count] = color;
        idx = color_count[pinp_pkg::IDX_W-1:0];
        color_count++;
      end else begin
        overflowed = 1'b1;
        color_count = PAL_SLOTS + 1;
        idx = '0;
      end
    end
    if (mirror_reg) begin
      w = width_reg;
      if (w < 2) w = 2;
      if (w > ROW_SLOTS) w = ROW_SLOTS;
      w = w & ~32'd1;
      row_nibbles[columns % ROW_SLOTS] = idx;
      columns++;
      if (columns >= w) emit_row();
    end else if (nibble_held) begin
      queue_result(pinp_pkg::KIND_BYTE, {8'h00, held_nibble, idx}, '0);
      nibble_held = 1'b0;
    end else begin
      held_nibble = idx;
      nibble_held = 1'b1;
    end
    if (eoi) begin
      if (nibble_held) begin
        queue_result(pinp_pkg::KIND_BYTE, {8'h00, held_nibble, 4'h0}, '0);
        nibble_held = 1'b0;
      end
      if (columns > 0) emit_row();
      if (overflowed) begin
        queue_result(pinp_pkg::KIND_OVERFLOW, 16'(PAL_SLOTS + 1), '0);
      end else begin
        for (int j = 0; j < color_count && j < PAL_SLOTS; j++) begin
          queue_result(pinp_pkg::KIND_PALETTE, colors[j], j[pinp_pkg::IDX_W-1:0]);
        end
      end
      color_count = 0;
      overflowed = 1'b0;
      held_nibble = '0;
      columns = 0;
    end
    if (due_results.size() > start) due_results[$].last = 1'b1;
  endtask

  task automatic flag(string field, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    pinp_pkg::result_t want;
    if (!rst_n) begin
      width_reg = pinp_pkg::ROW_WIDTH_RESET;
      mirror_reg = 1'b0;
      color_count = 0;
      overflowed = 1'b0;
      held_nibble = '0;
      nibble_held = 1'b0;
      columns = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: expected no transfer, got kind %h data %h slot %h last %b", $time,
                   out_result_kind, out_data_value, out_palette_slot, out_last_result);
        end else begin
          want = due_results.pop_front();
          if (out_result_kind !== want.kind) flag("result_kind", want.kind, out_result_kind);
          if (out_data_value !== want.data) flag("data_value", want.data, out_data_value);
          if (out_palette_slot !== want.slot) flag("palette_slot", want.slot, out_palette_slot);
          if (out_last_result !== want.last) flag("last_result", want.last, out_last_result);
        end
      end
      if (in_valid && !in_stall) encode_pixel({in_pixel_high, in_pixel_low}, in_end_of_image);
      if (cfg_we) begin
        if (cfg_index == pinp_pkg::CFG_ROW_WIDTH) width_reg = cfg_wdata;
        else mirror_reg = cfg_wdata[0];
      end
    end
    mismatches <= errors;
    awaiting <= due_results.size();
  end

endmodule

@@ bench/tb.sv @@
// Top of the packer testbench: clock, reset, pixel stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned TAIL        = 100;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_pixel_high = '0;
  logic [7:0]                       in_pixel_low = '0;
  logic                             in_end_of_image = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       out_result_kind;
  logic [15:0]                      out_data_value;
  logic [3:0]                       out_palette_slot;
  logic                             out_last_result;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = pinp_pkg::CFG_ROW_WIDTH;
  logic [pinp_pkg::ROW_WIDTH_W-1:0] cfg_wdata = '0;
  int unsigned                      mismatches;
  int unsigned                      awaiting;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 67;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  logic [pinp_pkg::COLOR_W-1:0] swatches [24];

  palette_index_nibble_packer_core dut (.*);
  pinp_monitor monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_pixel(logic [pinp_pkg::COLOR_W-1:0] color, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_high <= color[15:8];
    in_pixel_low <= color[7:0];
    in_end_of_image <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(logic [pinp_pkg::ROW_WIDTH_W-1:0] width, logic mirror);
    cfg_we <= 1'b1;
    cfg_index <= pinp_pkg::CFG_ROW_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= pinp_pkg::CFG_MIRROR;
    cfg_wdata <= {6'b0, mirror};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_swatches(int unsigned n);
    bit dup;
    for (int unsigned i = 0; i < n; i++) begin
      do begin
        swatches[i] = 16'($urandom);
        dup = 1'b0;
        for (int unsigned j = 0; j < i; j++) begin
          if (swatches[j] == swatches[i]) dup = 1'b1;
        end
      end while (dup);
    end
  endtask

  // The first pixels walk the swatch set, so an image as long as the set uses all its colors.
  task automatic send_image(int unsigned len, int unsigned ncolors, bit close);
    logic [pinp_pkg::COLOR_W-1:0] c;
    fill_swatches(ncolors);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < ncolors) c = swatches[i];
      else if (ncolors <= 8 && $urandom_range(11) == 0) c = 16'($urandom);
      else c = swatches[$urandom_range(ncolors - 1)];
      send_pixel(c, close && (i == len - 1));
    end
  endtask

  function automatic logic [pinp_pkg::ROW_WIDTH_W-1:0] pick_width();
    case ($urandom_range(5))
      0: return 7'd2;
      1: return 7'd64;
      2: return 7'($urandom_range(127));
      default: return 7'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned ncol;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Odd leftover nibble at image end, extreme colors.
    set_mode(7'd2, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    settle();
    // Width below range clamps to two.
    set_mode(7'd0, 1'b1);
    send_pixel(16'hAA55, 1'b0);
    send_pixel(16'h55AA, 1'b0);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hAA55, 1'b1);
    settle();
    // Odd width rounds down; the partial mirror row is padded.
    set_mode(7'd7, 1'b1);
    send_pixel(16'hF00F, 1'b0);
    send_pixel(16'h0FF0, 1'b0);
    send_pixel(16'hF00F, 1'b1);
    settle();
    // Mode switched mid-image: pending pair byte first, then the partial row.
    set_mode(7'd8, 1'b1);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h4002, 1'b0);
    send_pixel(16'h2004, 1'b0);
    settle();
    set_mode(7'd8, 1'b0);
    send_pixel(16'h1008, 1'b1);
    settle();
    // Width lowered mid-row flushes on the next pixel.
    set_mode(7'd64, 1'b1);
    send_pixel(16'h0102, 1'b0);
    send_pixel(16'h0304, 1'b0);
    send_pixel(16'h0506, 1'b0);
    send_pixel(16'h0708, 1'b0);
    send_pixel(16'h090A, 1'b0);
    settle();
    set_mode(7'd4, 1'b1);
    send_pixel(16'h0B0C, 1'b0);
    send_pixel(16'h0D0E, 1'b1);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 17 : 0;
      sent = 0;
      if (ph == 0) begin
        // Exactly a full palette, then one color too many.
        set_mode(7'd127, 1'b0);
        send_image(20, 16, 1'b1);
        settle();
        set_mode(pick_width(), 1'b1);
        send_image(22, 17, 1'b1);
        settle();
        sent = 42;
      end else if (ph == 2) begin
        // The longest burst comes out while the result side holds off and the next pixel waits.
        set_mode(7'd64, 1'b1);
        send_image(63, 16, 1'b0);
        hold_requests <= hold_requests + 1;
        send_pixel(swatches[$urandom_range(15)], 1'b1);
        send_pixel(swatches[$urandom_range(15)], 1'b0);
        settle();
        sent = 65;
      end
      while (sent < PHASE_ITEMS) begin
        set_mode(pick_width(), 1'($urandom_range(1)));
        ncol = ($urandom_range(3) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
        len = (ncol > 16) ? $urandom_range(ncol, 30) : $urandom_range(1, 24);
        send_image(len, ncol, $urandom_range(3) != 0);
        sent += len;
        settle();
      end
    end

    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pinp_pkg.sv
src/pinp_ram.sv
src/pinp_out_reg.sv
src/palette_index_nibble_packer_core.sv
bench/pinp_monitor.sv
bench/tb.sv
